// ===== src/scfb_pkg.sv =====
// Shared types and constants for the SPI command frame builder.
// No dependencies; used by every module of the block.
package scfb_pkg;

  // Link buffer size and derived widths. The fill level can pass the buffer
  // size by up to one frame of payload, so it carries that headroom.
  localparam int BUF_BYTES  = 4096;
  localparam int FRAME_MAX  = 128;
  localparam int FILL_W     = $clog2(BUF_BYTES + FRAME_MAX);
  localparam int CMP_W      = $clog2(BUF_BYTES + 2 * FRAME_MAX);
  localparam int POS_W      = 12;

  // Command queue between front and back
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [6:0] MAX_REPEAT = 7'd64;
  localparam logic [7:0] LEN_MIN    = 8'd4;
  localparam logic [7:0] LEN_MAX    = 8'd128;
  localparam logic [7:0] HDR_MARK   = 8'hE0;

  // Stream bytes of the single-byte commands
  localparam logic [7:0] BYTE_BREAK  = 8'h04;
  localparam logic [7:0] BYTE_FSYNC  = 8'h06;
  localparam logic [7:0] BYTE_FASYNC = 8'h05;
  localparam logic [7:0] BYTE_NOP    = 8'h00;

  typedef enum logic [2:0] {
    OP_BREAK  = 3'd0,
    OP_FSYNC  = 3'd1,
    OP_FASYNC = 3'd2,
    OP_NOP    = 3'd3,
    OP_HEADER = 3'd4,
    OP_DATA   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    op_t         op;
    logic [6:0]  count;   // saturated repeat count
    logic [15:0] addr;
    logic        len_ok;  // header length within 4..128
    logic [7:0]  byte0;   // command byte or first header byte
    logic [7:0]  size;    // payload bytes, whole words
    logic [7:0]  data;    // payload byte, already bit-reversed
  } cmd_t;

endpackage

// ===== src/scfb_front.sv =====
// Front end: accepts input beats and classifies them into queue commands.
// Depends on scfb_pkg.
module scfb_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [6:0]       in_repeat_count,
  input  logic [15:0]      in_target_addr,
  input  logic [7:0]       in_byte_length,
  input  logic [7:0]       in_data_byte,
  input  logic             q_ready,
  output logic             q_push,
  output scfb_pkg::cmd_t   q_cmd
);

  scfb_pkg::op_t op;
  logic [7:0]    hdr_byte;
  logic [7:0]    rev;

  assign op       = scfb_pkg::op_t'(in_op);
  assign in_stall = !q_ready;
  assign q_push   = in_valid && q_ready;

  // first header byte: (words - 1) | 0xE0
  assign hdr_byte = (8'({2'b00, in_byte_length[7:2]}) - 8'd1) | scfb_pkg::HDR_MARK;

  // payload goes out LSB first on the link
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rev[i] = in_data_byte[7-i];
    end
  end

  always_comb begin
    q_cmd.op     = op;
    q_cmd.count  = (in_repeat_count > scfb_pkg::MAX_REPEAT) ?
                   scfb_pkg::MAX_REPEAT : in_repeat_count;
    q_cmd.addr   = in_target_addr;
    q_cmd.len_ok = (in_byte_length >= scfb_pkg::LEN_MIN) &&
                   (in_byte_length <= scfb_pkg::LEN_MAX);
    q_cmd.size   = {in_byte_length[7:2], 2'b00};
    q_cmd.data   = rev;
    case (op)
      scfb_pkg::OP_BREAK:  q_cmd.byte0 = scfb_pkg::BYTE_BREAK;
      scfb_pkg::OP_FSYNC:  q_cmd.byte0 = scfb_pkg::BYTE_FSYNC;
      scfb_pkg::OP_FASYNC: q_cmd.byte0 = scfb_pkg::BYTE_FASYNC;
      scfb_pkg::OP_NOP:    q_cmd.byte0 = scfb_pkg::BYTE_NOP;
      scfb_pkg::OP_HEADER: q_cmd.byte0 = hdr_byte;
      default:             q_cmd.byte0 = 8'h00;
    endcase
  end

endmodule

// ===== src/scfb_queue.sv =====
// Short command FIFO between the front end and the sequencer.
// Depends on scfb_pkg.
module scfb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  scfb_pkg::cmd_t   push_cmd,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output scfb_pkg::cmd_t   head
);

  scfb_pkg::cmd_t                mem_r [scfb_pkg::QDEPTH];
  logic [scfb_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [scfb_pkg::QCNT_W-1:0]   count_r;

  assign ready      = (count_r != scfb_pkg::QCNT_W'(scfb_pkg::QDEPTH)) || pop;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== src/scfb_back.sv =====
// Back end: sequences each queued command into output beats and keeps the
// buffer fill level and payload tracking. Depends on scfb_pkg.
module scfb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  scfb_pkg::cmd_t             q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_kind,
  output logic [7:0]                 out_byte_value,
  output logic [scfb_pkg::POS_W-1:0] out_position,
  output logic                       out_data_ok,
  output logic                       out_last
);

  localparam logic [scfb_pkg::CMP_W-1:0] BUF_LIM = scfb_pkg::CMP_W'(scfb_pkg::BUF_BYTES);

  logic [scfb_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]                  left_r, left_nxt;
  logic                        acc_r, acc_nxt;
  logic [6:0]                  prog_r, prog_nxt;

  logic                        out_valid_r;
  logic                        kind_r, ok_r, last_r;
  logic [7:0]                  val_r;
  logic [scfb_pkg::POS_W-1:0]  pos_r;

  logic                        out_free, advance, done, emit;
  logic                        e_kind, e_ok, e_last;
  logic [7:0]                  e_val;
  logic [scfb_pkg::POS_W-1:0]  e_pos;
  logic                        fits1, fits2, fits3, fits_size;

  function automatic logic fits(input logic [scfb_pkg::FILL_W-1:0] f,
                                input logic [7:0] n);
    return (scfb_pkg::CMP_W'(f) + scfb_pkg::CMP_W'(n)) < BUF_LIM;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = q_valid && out_free;
  assign q_pop     = advance && done;
  assign fits1     = fits(fill_r, 8'd1);
  assign fits2     = fits(fill_r, 8'd2);
  assign fits3     = fits(fill_r, 8'd3);
  assign fits_size = fits(fill_r, q_head.size);

  // one step of the head command per cycle, while the queue has a command and the output is free
  always_comb begin
    done     = 1'b0;
    emit     = 1'b0;
    e_kind   = 1'b0;
    e_val    = 8'h00;
    e_pos    = scfb_pkg::POS_W'(fill_r);
    e_ok     = 1'b0;
    e_last   = 1'b0;
    fill_nxt = fill_r;
    left_nxt = left_r;
    acc_nxt  = acc_r;
    prog_nxt = prog_r;
    if (advance) begin
      case (q_head.op)
        scfb_pkg::OP_BREAK, scfb_pkg::OP_FSYNC: begin
          done = 1'b1;
          if (fits1) begin
            emit     = 1'b1;
            e_val    = q_head.byte0;
            e_last   = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
        scfb_pkg::OP_FASYNC, scfb_pkg::OP_NOP: begin
          if ((prog_r == q_head.count) || !fits1) begin
            done = 1'b1;
          end else begin
            // last when the count runs out or the next byte would not fit
            emit     = 1'b1;
            e_val    = q_head.byte0;
            e_last   = (7'(prog_r + 7'd1) == q_head.count) || !fits2;
            fill_nxt = fill_r + 1'b1;
            prog_nxt = prog_r + 7'd1;
            done     = e_last;
          end
        end
        scfb_pkg::OP_HEADER: begin
          if (!q_head.len_ok) begin
            emit     = 1'b1;
            e_kind   = 1'b1;
            e_pos    = '0;
            e_last   = 1'b1;
            left_nxt = 8'd0;
            acc_nxt  = 1'b0;
            done     = 1'b1;
          end else if ((prog_r == 7'd0) && fits3) begin
            emit     = 1'b1;
            e_val    = q_head.byte0;
            fill_nxt = fill_r + 1'b1;
            prog_nxt = 7'd1;
          end else if (prog_r == 7'd1) begin
            emit     = 1'b1;
            e_val    = q_head.addr[15:8];
            fill_nxt = fill_r + 1'b1;
            prog_nxt = 7'd2;
          end else if (prog_r == 7'd2) begin
            emit     = 1'b1;
            e_val    = q_head.addr[7:0];
            fill_nxt = fill_r + 1'b1;
            prog_nxt = 7'd3;
          end else begin
            // status beat, checked against the level after any header bytes that went out
            emit     = 1'b1;
            e_kind   = 1'b1;
            e_ok     = fits_size;
            e_pos    = fits_size ? scfb_pkg::POS_W'(fill_r) : '0;
            e_last   = 1'b1;
            left_nxt = q_head.size;
            acc_nxt  = fits_size;
            done     = 1'b1;
          end
        end
        scfb_pkg::OP_DATA: begin
          done = 1'b1;
          if (left_r != 8'd0) begin
            left_nxt = left_r - 8'd1;
            if (acc_r) begin
              emit     = 1'b1;
              e_val    = q_head.data;
              e_last   = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end
            if (left_r == 8'd1) acc_nxt = 1'b0;
          end
        end
        scfb_pkg::OP_CLEAR: begin
          fill_nxt = '0;
          left_nxt = 8'd0;
          acc_nxt  = 1'b0;
          done     = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) prog_nxt = 7'd0;
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      left_r <= 8'd0;
      acc_r  <= 1'b0;
      prog_r <= 7'd0;
    end else begin
      fill_r <= fill_nxt;
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
      prog_r <= prog_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      kind_r <= e_kind;
      val_r  <= e_val;
      pos_r  <= e_pos;
      ok_r   <= e_ok;
      last_r <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte_value = val_r;
  assign out_position   = pos_r;
  assign out_data_ok    = ok_r;
  assign out_last       = last_r;

endmodule

// ===== src/spi_command_frame_builder.sv =====
// SPI command frame builder: top level joining front end, queue and sequencer.
// Depends on scfb_pkg, scfb_front, scfb_queue and scfb_back.
//
// Turns one command per input beat into the byte stream for a chained ASIC
// link, one output beat per cycle while the output is not stalled. Break,
// fsync and data-byte commands emit at most one byte; fasync and nop emit
// n bytes, n being the repeat bytes that still fit in the buffer (repeats are
// capped at 64); a data header emits its three bytes when they fit and then
// its status beat, else only the status beat. Commands that give no output
// (dropped chunks, stray data bytes, clear, unused opcode) emit no beat. The
// sequencer that emits bytes sets the output rate; a two-entry command queue
// in front of it lets input and output stall independently.
// Position is the buffer index modulo 4096.
module spi_command_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [6:0]  in_repeat_count,
  input  logic [15:0] in_target_addr,
  input  logic [7:0]  in_byte_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte_value,
  output logic [11:0] out_position,
  output logic        out_data_ok,
  output logic        out_last
);

  logic           q_ready, q_push, q_pop, q_valid;
  scfb_pkg::cmd_t q_cmd, q_head;

  scfb_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_repeat_count (in_repeat_count),
    .in_target_addr  (in_target_addr),
    .in_byte_length  (in_byte_length),
    .in_data_byte    (in_data_byte),
    .q_ready         (q_ready),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  scfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  scfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte_value (out_byte_value),
    .out_position   (out_position),
    .out_data_ok    (out_data_ok),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  // a status beat always closes its header command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("status beat without last");

  // a rejected header reports offset zero and no byte
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && !out_data_ok |-> (out_position == 12'd0) &&
    (out_byte_value == 8'h00))
    else $error("rejected header with nonzero fields");

  // stream beats never flag data_ok
  a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_data_ok)
    else $error("stream beat with data_ok set");
`endif

endmodule

// ===== test/spi_command_frame_builder_test.sv =====
// Self-checking testbench for spi_command_frame_builder: random and directed commands,
// with a scoreboard that predicts every link byte and header status beat.
// Depends on scfb_pkg and the spi_command_frame_builder RTL.
module spi_command_frame_builder_test;
  import scfb_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int ITEMS         = 480;
  localparam int HALF_PERIOD   = 10;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int SETTLE_CYCLES = 50;

  // One output beat as seen on the result channel
  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [11:0] position;
    logic        data_ok;
    logic        last;
  } link_beat_t;

  // Tracks buffer fill and frame state, holds the beats still owed by the block
  class frame_scoreboard;
    int unsigned fill;
    int unsigned payload_left;
    bit          payload_taken;
    link_beat_t  pending_q[$];
    int          errors;

    function void clear_state();
      fill          = 0;
      payload_left  = 0;
      payload_taken = 0;
    endfunction

    task report(string what);
      errors++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    // A chunk is taken only if its end stays below the buffer size
    function bit room_for(int unsigned n);
      return fill + n < BUF_BYTES;
    endfunction

    function void push_stream(logic [7:0] b);
      link_beat_t e;
      e            = '0;
      e.byte_value = b;
      e.position   = fill[POS_W-1:0];
      pending_q.push_back(e);
      fill++;
    endfunction

    function logic [7:0] mirror_bits(logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = b[7 - i];
      return r;
    endfunction

    // Accepted command beat: append the beats it must cause
    function void note_command(logic [2:0] op, logic [6:0] reps, logic [15:0] addr,
                               logic [7:0] len, logic [7:0] payload);
      int unsigned first;
      int unsigned n;
      int unsigned size;
      link_beat_t  status;
      first = pending_q.size();
      case (op)
        OP_BREAK: if (room_for(1)) push_stream(BYTE_BREAK);
        OP_FSYNC: if (room_for(1)) push_stream(BYTE_FSYNC);
        OP_FASYNC, OP_NOP: begin
          n = (reps > MAX_REPEAT) ? MAX_REPEAT : reps;
          repeat (n) begin
            if (room_for(1)) push_stream(op == OP_FASYNC ? BYTE_FASYNC : BYTE_NOP);
          end
        end
        OP_HEADER: begin
          status        = '0;
          status.kind   = 1'b1;
          payload_left  = 0;
          payload_taken = 0;
          if (len >= LEN_MIN && len <= LEN_MAX) begin
            size = (len / 4) * 4;
            if (room_for(3)) begin
              push_stream(HDR_MARK | 8'(size / 4 - 1));
              push_stream(addr[15:8]);
              push_stream(addr[7:0]);
            end
            payload_left = size;
            // payload space is reserved up front, checked after the header bytes
            if (room_for(size)) begin
              status.data_ok  = 1'b1;
              status.position = fill[POS_W-1:0];
              payload_taken   = 1;
            end
          end
          pending_q.push_back(status);
        end
        OP_DATA: begin
          if (payload_left > 0) begin
            payload_left--;
            if (payload_taken) push_stream(mirror_bits(payload));
            if (payload_left == 0) payload_taken = 0;
          end
        end
        OP_CLEAR: clear_state();
        default: ;
      endcase
      if (pending_q.size() > first) pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    // Accepted output beat: compare with the oldest owed beat
    task check_result(link_beat_t got);
      link_beat_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat kind=%0d byte=%02h pos=%0d ok=%0d last=%0d",
                         got.kind, got.byte_value, got.position, got.data_ok, got.last));
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.byte_value !== want.byte_value)
        report($sformatf("byte_value %02h, want %02h", got.byte_value, want.byte_value));
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.data_ok !== want.data_ok)
        report($sformatf("data_ok %0d, want %0d", got.data_ok, want.data_ok));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op           = '0;
  logic [6:0]  in_repeat_count = '0;
  logic [15:0] in_target_addr  = '0;
  logic [7:0]  in_byte_length  = '0;
  logic [7:0]  in_data_byte    = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte_value;
  logic [11:0] out_position;
  logic        out_data_ok;
  logic        out_last;

  frame_scoreboard sb;
  bit tx_on      = 0;   // value currently driven on in_valid
  int tx_gap     = 0;   // idle cycles before the next input beat
  bit tx_eager   = 0;
  bit rx_eager   = 0;
  int rx_hold    = 0;   // stall cycles left on the result side
  int items_done = 0;   // command beats that had an effect

  spi_command_frame_builder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_repeat_count (in_repeat_count),
    .in_target_addr  (in_target_addr),
    .in_byte_length  (in_byte_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte_value  (out_byte_value),
    .out_position    (out_position),
    .out_data_ok     (out_data_ok),
    .out_last        (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // Result side: check each accepted beat, then stall a random while
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result({out_kind, out_byte_value, out_position, out_data_ok, out_last});
        rx_hold = rx_eager ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one command beat and wait for it to be taken
  task automatic issue(input logic [2:0] op, input logic [6:0] reps, input logic [15:0] addr,
                       input logic [7:0] len, input logic [7:0] payload);
    bit counts;
    if (!tx_on) repeat ((tx_gap > 0) ? tx_gap : 1) @(posedge clk);
    in_valid        <= 1'b1;
    in_op           <= op;
    in_repeat_count <= reps;
    in_target_addr  <= addr;
    in_byte_length  <= len;
    in_data_byte    <= payload;
    tx_on = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    counts = (op != OP_UNUSED) && !(op == OP_DATA && sb.payload_left == 0);
    if (counts) items_done++;
    sb.note_command(op, reps, addr, len, payload);
    tx_gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_on = 0;
    end
  endtask

  task automatic wait_idle();
    if (tx_on) begin
      in_valid <= 1'b0;
      tx_on = 0;
    end
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Header followed by its payload, sometimes cut short, overrun or interleaved
  task automatic send_frame();
    int pick;
    int beats;
    logic [7:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 70)      len = 8'($urandom_range(4, 32));
    else if (pick < 85) len = 8'($urandom_range(4, 128));
    else                len = 8'($urandom);
    issue(OP_HEADER, 7'($urandom), 16'($urandom), len, 8'($urandom));
    beats = sb.payload_left;
    pick  = $urandom_range(0, 9);
    if (pick == 0)      beats = $urandom_range(0, beats);
    else if (pick == 1) beats += $urandom_range(1, 3);
    repeat (beats) begin
      if ($urandom_range(0, 9) == 0)
        issue(3'($urandom_range(0, 3)), 7'($urandom_range(0, 8)), 16'($urandom),
              8'($urandom), 8'($urandom));
      issue(OP_DATA, 7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_traffic(input int n);
    int stop;
    int pick;
    stop = items_done + n;
    while (items_done < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_frame();
      else if (pick < 80)
        issue(3'($urandom_range(0, 7)), 7'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom));
      else if (pick < 96)
        issue($urandom_range(0, 1) ? OP_FASYNC : OP_NOP, 7'($urandom_range(0, 70)),
              16'($urandom), 8'($urandom), 8'($urandom));
      else
        issue(OP_CLEAR, 7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single bytes, repeat extremes, header lengths, payload bytes
    issue(OP_BREAK,  7'd0,   16'h0000, 8'd0,   8'h00);
    issue(OP_FSYNC,  7'd0,   16'h0000, 8'd0,   8'h00);
    issue(OP_FASYNC, 7'd0,   16'h0000, 8'd0,   8'h00);  // zero repeats
    issue(OP_FASYNC, 7'd1,   16'h0000, 8'd0,   8'h00);
    issue(OP_NOP,    7'd64,  16'h0000, 8'd0,   8'h00);
    issue(OP_NOP,    7'd127, 16'h0000, 8'd0,   8'h00);  // saturates to 64
    issue(OP_HEADER, 7'd0,   16'hFFFF, 8'd3,   8'h00);  // too short
    issue(OP_HEADER, 7'd0,   16'hFFFF, 8'd129, 8'h00);  // too long
    issue(OP_HEADER, 7'd0,   16'h0000, 8'd0,   8'h00);
    issue(OP_HEADER, 7'd0,   16'hFFFF, 8'd4,   8'h00);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h00);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'hFF);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h01);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h80);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h3C);  // no payload pending
    issue(OP_UNUSED, 7'h7F,  16'hFFFF, 8'hFF,  8'hFF);
    issue(OP_HEADER, 7'd0,   16'h0000, 8'd128, 8'h00);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'hA5);
    issue(OP_HEADER, 7'd0,   16'h1234, 8'd7,   8'h00);  // abandons pending payload
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h0F);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'hF0);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'h5A);
    issue(OP_DATA,   7'd0,   16'h0000, 8'd0,   8'hC3);
    issue(OP_HEADER, 7'd0,   16'h0000, 8'd255, 8'h00);
    issue(OP_CLEAR,  7'd0,   16'h0000, 8'd0,   8'h00);

    // Buffer edge: header fits but payload does not, then header dropped
    repeat (62) issue(OP_NOP, MAX_REPEAT, 16'h0000, 8'd0, 8'h00);
    issue(OP_HEADER, 7'd0,  16'hA55A, 8'd128, 8'h00);
    repeat (4) issue(OP_DATA, 7'd0, 16'h0000, 8'd0, 8'($urandom));
    issue(OP_FASYNC, 7'd64, 16'h0000, 8'd0, 8'h00);
    issue(OP_FASYNC, 7'd58, 16'h0000, 8'd0, 8'h00);
    issue(OP_HEADER, 7'd0,  16'h5AA5, 8'd8, 8'h00);
    repeat (2) issue(OP_DATA, 7'd0, 16'h0000, 8'd0, 8'($urandom));
    issue(OP_BREAK,  7'd0,  16'h0000, 8'd0, 8'h00);
    issue(OP_FSYNC,  7'd0,  16'h0000, 8'd0, 8'h00);
    issue(OP_NOP,    7'd5,  16'h0000, 8'd0, 8'h00);
    issue(OP_BREAK,  7'd0,  16'h0000, 8'd0, 8'h00);
    issue(OP_CLEAR,  7'd0,  16'h0000, 8'd0, 8'h00);

    // Reserved payload outruns the buffer end after interleaved nops
    repeat (61) issue(OP_NOP, MAX_REPEAT, 16'h0000, 8'd0, 8'h00);
    issue(OP_HEADER, 7'd0,   16'hC0DE, 8'd8, 8'h00);
    issue(OP_NOP,    7'd127, 16'h0000, 8'd0, 8'h00);
    repeat (2) issue(OP_NOP, MAX_REPEAT, 16'h0000, 8'd0, 8'h00);
    repeat (8) issue(OP_DATA, 7'd0, 16'h0000, 8'd0, 8'($urandom));
    issue(OP_BREAK,  7'd0,   16'h0000, 8'd0, 8'h00);
    issue(OP_CLEAR,  7'd0,   16'h0000, 8'd0, 8'h00);
    wait_idle();

    // Random traffic
    random_traffic(100);
    tx_eager = 1;
    rx_eager = 1;
    random_traffic(40);
    tx_eager = 0;
    rx_eager = 0;
    wait_idle();

    // Fill close to the end of the buffer, then mix near the edge
    issue(OP_CLEAR, 7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    begin
      int unsigned target;
      target = $urandom_range(3700, 4090);
      while (sb.fill < target)
        issue($urandom_range(0, 1) ? OP_FASYNC : OP_NOP, 7'($urandom_range(64, 127)),
              16'($urandom), 8'($urandom), 8'($urandom));
    end
    random_traffic(40);
    issue(OP_CLEAR, 7'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));

    rx_eager = 1;
    random_traffic(40);
    rx_eager = 0;
    random_traffic(ITEMS - items_done);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("spi_command_frame_builder_test passed");
    else
      $display("spi_command_frame_builder_test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("spi_command_frame_builder_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/scfb_pkg.sv
src/scfb_front.sv
src/scfb_queue.sv
src/scfb_back.sv
src/spi_command_frame_builder.sv
test/spi_command_frame_builder_test.sv
